// ===== design/vtss_pkg.sv =====
// vtss_pkg: shared constants, codes and controller/datapath bundles
// for the value table block; used by every module in the design folder
// depends on nothing
package vtss_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int DATA_W = 32;

   // fixed field widths of the stream words
   localparam int CMD_W = 3;
   localparam int KIND_W = 2;
   localparam int ENTRY_INDEX_W = 6;
   localparam int STATUS_W = 2;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 40;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND  = 3'd0,
      CMD_DISPLAY = 3'd1,
      CMD_SORT    = 3'd2,
      CMD_SEARCH  = 3'd3,
      CMD_DELETE  = 3'd4
   } command_type;

   // result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_ENTRY  = 2'd0,
      KIND_MATCH  = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   // status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   // walk index updates (i is port a address, j is port b address)
   typedef enum logic [2:0] {
      IDX_HOLD   = 3'd0,
      IDX_CLEAR  = 3'd1,
      IDX_NEXT_I = 3'd2,
      IDX_NEXT_J = 3'd3,
      IDX_LOC    = 3'd4,
      IDX_STEP   = 3'd5
   } idx_op_type;

   // table writes
   typedef enum logic [1:0] {
      WR_NONE   = 2'd0,
      WR_APPEND = 2'd1,
      WR_I_B    = 2'd2,
      WR_J_A    = 2'd3
   } wr_op_type;

   // entry count updates
   typedef enum logic [1:0] {
      CNT_HOLD = 2'd0,
      CNT_INC  = 2'd1,
      CNT_DEC  = 2'd2
   } cnt_op_type;

   // which result word to load into the output register
   typedef enum logic [1:0] {
      OUT_NONE   = 2'd0,
      OUT_ENTRY  = 2'd1,
      OUT_MATCH  = 2'd2,
      OUT_STATUS = 2'd3
   } out_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        take_req;
      logic        rd_en;
      idx_op_type  idx_op;
      wr_op_type   wr_op;
      cnt_op_type  cnt_op;
      logic        pend_set;
      logic        pend_clr;
      logic        loc_set;
      logic        loc_clr;
      out_sel_type out_sel;
      logic        out_last;
      status_type  out_status;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
      logic single;
      logic out_free;
      logic i_last;
      logic i_near_last;
      logic j_last;
      logic j_past;
      logic match;
      logic greater;
      logic pend_valid;
      logic found;
   } dp_stat_type;

endpackage

// ===== design/vtss_dp.sv =====
// vtss_dp: value table datapath: table memory, count, walk indexes,
// match bookkeeping and the result output register
// depends on vtss_pkg
module vtss_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [vtss_pkg::REQ_TDATA_W-1:0]   req_tdata,   // [31:0] operand_value
   input  vtss_pkg::dp_cmd_type               cmd,
   output vtss_pkg::dp_stat_type              stat,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [5:0] entry_index, [37:6] entry_value, [39:38] status
   output logic [vtss_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic [vtss_pkg::KIND_W-1:0]        rsp_tuser,   // [1:0] result_kind
   output logic                               rsp_tlast    // last
);

   localparam int CW = vtss_pkg::CNT_W;
   localparam int IW = vtss_pkg::IDX_W;
   localparam int DW = vtss_pkg::DATA_W;

   // table memory, undefined until written
   logic signed [DW-1:0] mem [vtss_pkg::TABLE_DEPTH];

   logic signed [DW-1:0] rd_a_ff, rd_b_ff;
   logic signed [DW-1:0] operand_ff, operand_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        i_ff, i_in, j_ff, j_in;
   logic [IW-1:0]        loc_ff, loc_in;
   logic                 found_ff, found_in;
   logic [IW-1:0]        pend_idx_ff, pend_idx_in;
   logic                 pend_valid_ff, pend_valid_in;

   logic                 out_valid_ff, out_valid_in;
   vtss_pkg::kind_type   out_kind_ff, out_kind_in;
   logic [vtss_pkg::ENTRY_INDEX_W-1:0] out_idx_ff, out_idx_in;
   logic signed [DW-1:0] out_value_ff, out_value_in;
   vtss_pkg::status_type out_status_ff, out_status_in;
   logic                 out_last_ff, out_last_in;

   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   logic signed [DW-1:0] wr_data;
   logic [CW:0]          i_plus1, i_plus2, j_plus1;

   // table memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_a_ff <= mem[i_ff[IW-1:0]];
         rd_b_ff <= mem[j_ff[IW-1:0]];
      end
   end

   // write address and data
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = i_ff[IW-1:0];
      wr_data = rd_b_ff;
      case (cmd.wr_op)
         vtss_pkg::WR_APPEND: begin
            wr_en   = 1'b1;
            wr_addr = count_ff[IW-1:0];
            wr_data = operand_ff;
         end
         vtss_pkg::WR_I_B: begin
            wr_en   = 1'b1;
            wr_addr = i_ff[IW-1:0];
            wr_data = rd_b_ff;
         end
         vtss_pkg::WR_J_A: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[IW-1:0];
            wr_data = rd_a_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // status toward the controller
   assign i_plus1 = {1'b0, i_ff} + (CW+1)'(1);
   assign i_plus2 = {1'b0, i_ff} + (CW+1)'(2);
   assign j_plus1 = {1'b0, j_ff} + (CW+1)'(1);

   always_comb begin
      stat.empty       = (count_ff == '0);
      stat.full        = (count_ff >= CW'(vtss_pkg::TABLE_DEPTH));
      stat.single      = (count_ff <= CW'(1));
      stat.out_free    = !out_valid_ff || rsp_tready;
      stat.i_last      = (i_plus1 >= {1'b0, count_ff});
      stat.i_near_last = (i_plus2 >= {1'b0, count_ff});
      stat.j_last      = (j_plus1 >= {1'b0, count_ff});
      stat.j_past      = (j_ff >= count_ff);
      stat.match       = (rd_a_ff == operand_ff);
      stat.greater     = (rd_a_ff > rd_b_ff);
      stat.pend_valid  = pend_valid_ff;
      stat.found       = found_ff;
   end

   // operand, count, walk indexes and match bookkeeping
   always_comb begin
      operand_in = cmd.take_req ? $signed(req_tdata[DW-1:0]) : operand_ff;

      case (cmd.cnt_op)
         vtss_pkg::CNT_INC: count_in = count_ff + CW'(1);
         vtss_pkg::CNT_DEC: count_in = count_ff - CW'(1);
         default:           count_in = count_ff;
      endcase

      i_in = i_ff;
      j_in = j_ff;
      case (cmd.idx_op)
         vtss_pkg::IDX_CLEAR: begin
            i_in = '0;
            j_in = CW'(1);
         end
         vtss_pkg::IDX_NEXT_I: begin
            i_in = i_plus1[CW-1:0];
            j_in = i_plus2[CW-1:0];
         end
         vtss_pkg::IDX_NEXT_J: begin
            j_in = j_plus1[CW-1:0];
         end
         vtss_pkg::IDX_LOC: begin
            i_in = CW'(loc_ff);
            j_in = CW'(loc_ff) + CW'(1);
         end
         vtss_pkg::IDX_STEP: begin
            i_in = i_plus1[CW-1:0];
            j_in = j_plus1[CW-1:0];
         end
         default: begin
            i_in = i_ff;
         end
      endcase

      loc_in   = cmd.loc_set ? i_ff[IW-1:0] : loc_ff;
      found_in = cmd.loc_clr ? 1'b0 : (cmd.loc_set ? 1'b1 : found_ff);

      pend_idx_in   = cmd.pend_set ? i_ff[IW-1:0] : pend_idx_ff;
      pend_valid_in = cmd.pend_clr ? 1'b0 : (cmd.pend_set ? 1'b1 : pend_valid_ff);
   end

   // result output register
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_kind_in   = out_kind_ff;
      out_idx_in    = out_idx_ff;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      case (cmd.out_sel)
         vtss_pkg::OUT_ENTRY: begin
            out_valid_in  = 1'b1;
            out_kind_in   = vtss_pkg::KIND_ENTRY;
            out_idx_in    = vtss_pkg::ENTRY_INDEX_W'(i_ff[IW-1:0]);
            out_value_in  = rd_a_ff;
            out_status_in = vtss_pkg::ST_OK;
            out_last_in   = stat.i_last;
         end
         vtss_pkg::OUT_MATCH: begin
            out_valid_in  = 1'b1;
            out_kind_in   = vtss_pkg::KIND_MATCH;
            out_idx_in    = vtss_pkg::ENTRY_INDEX_W'(pend_idx_ff);
            out_value_in  = operand_ff;
            out_status_in = vtss_pkg::ST_OK;
            out_last_in   = cmd.out_last;
         end
         vtss_pkg::OUT_STATUS: begin
            out_valid_in  = 1'b1;
            out_kind_in   = vtss_pkg::KIND_STATUS;
            out_idx_in    = '0;
            out_value_in  = '0;
            out_status_in = cmd.out_status;
            out_last_in   = 1'b1;
         end
         default: begin
            out_last_in = out_last_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         found_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         found_ff      <= found_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      operand_ff    <= operand_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      loc_ff        <= loc_in;
      pend_idx_ff   <= pend_idx_in;
      out_kind_ff   <= out_kind_in;
      out_idx_ff    <= out_idx_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   // result port
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_status_ff, out_value_ff, out_idx_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== design/vtss_ctrl.sv =====
// vtss_ctrl: command sequencer for the value table; steps the datapath
// through append, display, exchange sort, search and delete walks
// depends on vtss_pkg
module vtss_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [vtss_pkg::CMD_W-1:0]    req_tuser,   // [2:0] command
   input  vtss_pkg::dp_stat_type         stat,
   output vtss_pkg::dp_cmd_type          cmd
);

   typedef enum logic [15:0] {
      S_IDLE      = 16'h0001,
      S_DECODE    = 16'h0002,
      S_STATUS    = 16'h0004,
      S_DISP_RD   = 16'h0008,
      S_DISP_OUT  = 16'h0010,
      S_SORT_RD   = 16'h0020,
      S_SORT_CMP  = 16'h0040,
      S_SORT_SWAP = 16'h0080,
      S_SRCH_RD   = 16'h0100,
      S_SRCH_CHK  = 16'h0200,
      S_SRCH_END  = 16'h0400,
      S_DEL_RD    = 16'h0800,
      S_DEL_CHK   = 16'h1000,
      S_DEL_LOC   = 16'h2000,
      S_SHIFT_RD  = 16'h4000,
      S_SHIFT_WR  = 16'h8000
   } state_type;

   state_type             state_ff, state_in;
   vtss_pkg::command_type op_ff, op_in;
   vtss_pkg::status_type  st_ff, st_in;

   assign req_tready = (state_ff == S_IDLE);

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      st_in    = st_ff;
      cmd      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.take_req = 1'b1;
               op_in        = vtss_pkg::command_type'(req_tuser);
               state_in     = S_DECODE;
            end
         end

         S_DECODE: begin
            case (op_ff)
               vtss_pkg::CMD_APPEND: begin
                  if (stat.full) begin
                     st_in = vtss_pkg::ST_FULL;
                  end else begin
                     cmd.wr_op  = vtss_pkg::WR_APPEND;
                     cmd.cnt_op = vtss_pkg::CNT_INC;
                     st_in      = vtss_pkg::ST_OK;
                  end
                  state_in = S_STATUS;
               end
               vtss_pkg::CMD_DISPLAY: begin
                  if (stat.empty) begin
                     st_in    = vtss_pkg::ST_EMPTY;
                     state_in = S_STATUS;
                  end else begin
                     cmd.idx_op = vtss_pkg::IDX_CLEAR;
                     state_in   = S_DISP_RD;
                  end
               end
               vtss_pkg::CMD_SORT: begin
                  if (stat.empty) begin
                     st_in    = vtss_pkg::ST_EMPTY;
                     state_in = S_STATUS;
                  end else begin
                     cmd.idx_op = vtss_pkg::IDX_CLEAR;
                     state_in   = stat.single ? S_DISP_RD : S_SORT_RD;
                  end
               end
               vtss_pkg::CMD_SEARCH: begin
                  if (stat.empty) begin
                     st_in    = vtss_pkg::ST_EMPTY;
                     state_in = S_STATUS;
                  end else begin
                     cmd.idx_op   = vtss_pkg::IDX_CLEAR;
                     cmd.pend_clr = 1'b1;
                     state_in     = S_SRCH_RD;
                  end
               end
               vtss_pkg::CMD_DELETE: begin
                  if (stat.empty) begin
                     st_in    = vtss_pkg::ST_EMPTY;
                     state_in = S_STATUS;
                  end else begin
                     cmd.idx_op  = vtss_pkg::IDX_CLEAR;
                     cmd.loc_clr = 1'b1;
                     state_in    = S_DEL_RD;
                  end
               end
               default: begin
                  // unused command codes are dropped without a result
                  state_in = S_IDLE;
               end
            endcase
         end

         // single status word closes the command
         S_STATUS: begin
            if (stat.out_free) begin
               cmd.out_sel    = vtss_pkg::OUT_STATUS;
               cmd.out_status = st_ff;
               state_in       = S_IDLE;
            end
         end

         // display walk: read entry i, then emit it
         S_DISP_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_DISP_OUT;
         end
         S_DISP_OUT: begin
            if (stat.out_free) begin
               cmd.out_sel = vtss_pkg::OUT_ENTRY;
               if (stat.i_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_op = vtss_pkg::IDX_STEP;
                  state_in   = S_DISP_RD;
               end
            end
         end

         // exchange sort: compare entry i with entry j, swap if out of order
         S_SORT_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_SORT_CMP;
         end
         S_SORT_CMP, S_SORT_SWAP: begin
            if (state_ff == S_SORT_CMP && stat.greater) begin
               cmd.wr_op = vtss_pkg::WR_I_B;
               state_in  = S_SORT_SWAP;
            end else begin
               if (state_ff == S_SORT_SWAP) begin
                  cmd.wr_op = vtss_pkg::WR_J_A;
               end
               if (!stat.j_last) begin
                  cmd.idx_op = vtss_pkg::IDX_NEXT_J;
                  state_in   = S_SORT_RD;
               end else if (!stat.i_near_last) begin
                  cmd.idx_op = vtss_pkg::IDX_NEXT_I;
                  state_in   = S_SORT_RD;
               end else begin
                  cmd.idx_op = vtss_pkg::IDX_CLEAR;
                  state_in   = S_DISP_RD;
               end
            end
         end

         // search walk: one match is held back so the final one carries last
         S_SRCH_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_SRCH_CHK;
         end
         S_SRCH_CHK: begin
            if (!(stat.match && stat.pend_valid && !stat.out_free)) begin
               if (stat.match) begin
                  cmd.pend_set = 1'b1;
                  if (stat.pend_valid) begin
                     cmd.out_sel  = vtss_pkg::OUT_MATCH;
                     cmd.out_last = 1'b0;
                  end
               end
               if (stat.i_last) begin
                  state_in = S_SRCH_END;
               end else begin
                  cmd.idx_op = vtss_pkg::IDX_STEP;
                  state_in   = S_SRCH_RD;
               end
            end
         end
         S_SRCH_END: begin
            if (stat.out_free) begin
               if (stat.pend_valid) begin
                  cmd.out_sel  = vtss_pkg::OUT_MATCH;
                  cmd.out_last = 1'b1;
               end else begin
                  cmd.out_sel    = vtss_pkg::OUT_STATUS;
                  cmd.out_status = vtss_pkg::ST_NOT_FOUND;
               end
               state_in = S_IDLE;
            end
         end

         // delete walk: remember the last match position
         S_DEL_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_DEL_CHK;
         end
         S_DEL_CHK: begin
            cmd.loc_set = stat.match;
            if (stat.i_last) begin
               if (stat.match || stat.found) begin
                  state_in = S_DEL_LOC;
               end else begin
                  st_in    = vtss_pkg::ST_NOT_FOUND;
                  state_in = S_STATUS;
               end
            end else begin
               cmd.idx_op = vtss_pkg::IDX_STEP;
               state_in   = S_DEL_RD;
            end
         end
         S_DEL_LOC: begin
            cmd.idx_op = vtss_pkg::IDX_LOC;
            state_in   = S_SHIFT_RD;
         end

         // close the gap: move entry j down to i until j reaches the count
         S_SHIFT_RD: begin
            if (stat.j_past) begin
               cmd.cnt_op = vtss_pkg::CNT_DEC;
               st_in      = vtss_pkg::ST_OK;
               state_in   = S_STATUS;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_op  = vtss_pkg::WR_I_B;
            cmd.idx_op = vtss_pkg::IDX_STEP;
            state_in   = S_SHIFT_RD;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // latched command and pending status code
   always_ff @(posedge clock) begin
      op_ff <= op_in;
      st_ff <= st_in;
   end

endmodule

// ===== design/value_table_sort_search_delete.sv =====
// Value table with append, display, exchange sort, search and delete.
// Append gives a status word; display emits the entries in order; search and
// delete scan every entry, and delete then shifts each later entry down; sort
// compares and, when out of order, exchanges entries over n*(n-1)/2 pairs.
// One command at a time: the next word is taken in the cycle after the final
// result is loaded, and a held result stalls the walk.
// Reset clears the entry count; table contents persist.
module value_table_sort_search_delete (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [vtss_pkg::REQ_TDATA_W-1:0]   req_tdata,   // [31:0] operand_value
   input  logic [vtss_pkg::CMD_W-1:0]         req_tuser,   // [2:0] command
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [5:0] entry_index, [37:6] entry_value, [39:38] status
   output logic [vtss_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic [vtss_pkg::KIND_W-1:0]        rsp_tuser,   // [1:0] result_kind
   output logic                               rsp_tlast    // last
);

   vtss_pkg::dp_cmd_type  dp_cmd;
   vtss_pkg::dp_stat_type dp_stat;

   // command sequencer
   vtss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat       (dp_stat),
      .cmd        (dp_cmd)
   );

   // table storage and result register
   vtss_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (dp_cmd),
      .stat       (dp_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
